### rtl/afr_pkg.sv
// Shared types, constants and helper functions of the ASCII frame receiver.
package afr_pkg;

   // Frame store size; the receiver resets when the write count reaches BUF_LEN - 1.
   localparam int unsigned BUF_LEN = 256;
   localparam logic [7:0] WC_LIMIT = 8'(BUF_LEN - 1);

   localparam logic [7:0] CHAR_START = 8'h3A;
   localparam logic [7:0] CHAR_END   = 8'h7E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] ANGLE_180  = 8'd180;
   localparam logic [7:0] ANGLE_0    = 8'd0;

   localparam logic [7:0] IDX_LEN_HI   = 8'd9;
   localparam logic [7:0] IDX_LEN_LO   = 8'd10;
   localparam logic [7:0] IDX_REPLY_HI = 8'd13;
   localparam logic [7:0] IDX_REPLY_LO = 8'd14;

   localparam logic [7:0] NEED_SHORT = 8'd2;
   localparam logic [7:0] NEED_LONG  = 8'd4;

   localparam logic [7:0] RST_LENGTH_OFFSET  = 8'd16;
   localparam logic [7:0] RST_RECORD_COUNT   = 8'd20;
   localparam logic [7:0] RST_VERSION_COUNT  = 8'd47;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LENGTH_OFFSET = 2'd0;
   localparam logic [1:0] CSR_RECORD_COUNT  = 2'd1;
   localparam logic [1:0] CSR_VERSION_COUNT = 2'd2;

   // Request modes.
   localparam logic [2:0] MODE_NONE    = 3'd0;
   localparam logic [2:0] MODE_PACK    = 3'd1;
   localparam logic [2:0] MODE_RECORD  = 3'd2;
   localparam logic [2:0] MODE_ANGLE   = 3'd3;
   localparam logic [2:0] MODE_PLACE   = 3'd4;
   localparam logic [2:0] MODE_VERSION = 3'd5;

   // Frame end codes.
   localparam logic [1:0] FEND_NONE    = 2'd0;
   localparam logic [1:0] FEND_GENERAL = 2'd1;
   localparam logic [1:0] FEND_ANGLE   = 2'd2;
   localparam logic [1:0] FEND_PLACE   = 2'd3;

   typedef enum logic [7:0] {
      PH_HUNT = 8'b0000_0001,
      PH_ADDR = 8'b0000_0010,
      PH_CMD  = 8'b0000_0100,
      PH_VER  = 8'b0000_1000,
      PH_LEN  = 8'b0001_0000,
      PH_DATA = 8'b0010_0000,
      PH_CSUM = 8'b0100_0000,
      PH_EOI  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] length_offset;
      logic [7:0] record_data_count;
      logic [7:0] version_data_count;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic [2:0] mode;
   } item_type;

   typedef struct packed {
      logic       stored;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic [1:0] frame_end;
      logic       overflow_reset;
      logic       angle_flag;
      logic       place_flag;
   } result_type;

   // Value of one ASCII hex digit; any other character counts as zero.
   function automatic logic [3:0] hex_digit(input logic [7:0] c);
      logic [7:0] t;
      t = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
         t = c - CHAR_ZERO;
      end else if (c inside {[8'h41:8'h46]}) begin
         t = c - CHAR_UA + 8'd10;
      end else if (c inside {[8'h61:8'h66]}) begin
         t = c - CHAR_LA + 8'd10;
      end
      return t[3:0];
   endfunction

   function automatic phase_type next_phase(input phase_type p);
      phase_type n;
      case (p)
         PH_HUNT: n = PH_ADDR;
         PH_ADDR: n = PH_CMD;
         PH_CMD:  n = PH_VER;
         PH_VER:  n = PH_LEN;
         PH_LEN:  n = PH_DATA;
         PH_DATA: n = PH_CSUM;
         PH_CSUM: n = PH_EOI;
         default: n = PH_HUNT;
      endcase
      return n;
   endfunction

endpackage

### rtl/afr_ifs.sv
// Channel interfaces of the ASCII frame receiver: byte input, result output, register writes.
interface afr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic [2:0] mode;
   modport source (output valid, rx_byte, mode, input ready);
   modport sink (input valid, rx_byte, mode, output ready);
endinterface

interface afr_rsp_if;
   logic       valid;
   logic       ready;
   logic       stored;
   logic [7:0] store_index;
   logic [7:0] store_byte;
   logic [1:0] frame_end;
   logic       overflow_reset;
   logic       angle_flag;
   logic       place_flag;
   modport source (output valid, stored, store_index, store_byte, frame_end,
                   overflow_reset, angle_flag, place_flag, input ready);
   modport sink (input valid, stored, store_index, store_byte, frame_end,
                 overflow_reset, angle_flag, place_flag, output ready);
endinterface

interface afr_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] wr_index;
   logic [7:0] wr_data;
   modport source (output valid, wr_index, wr_data, input ready);
   modport sink (input valid, wr_index, wr_data, output ready);
endinterface

### rtl/afr_csr_regs.sv
// Configuration registers of the ASCII frame receiver.
module afr_csr_regs
   import afr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   afr_csr_if.sink     csr_ch,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.wr_index)
            CSR_LENGTH_OFFSET: cfg_in.length_offset      = csr_ch.wr_data;
            CSR_RECORD_COUNT:  cfg_in.record_data_count  = csr_ch.wr_data;
            CSR_VERSION_COUNT: cfg_in.version_data_count = csr_ch.wr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.length_offset      <= RST_LENGTH_OFFSET;
         cfg_ff.record_data_count  <= RST_RECORD_COUNT;
         cfg_ff.version_data_count <= RST_VERSION_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/afr_in_stage.sv
// Input register stage: holds one received byte and its mode until the parser takes it.
module afr_in_stage
   import afr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   afr_req_if.sink     req_ch,
   output logic        item_valid,
   output item_type    item,
   input  logic        item_take
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_ch.ready = !valid_ff || item_take;
   assign item_valid   = valid_ff;
   assign item         = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.valid && req_ch.ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff.rx_byte <= req_ch.rx_byte;
         item_ff.mode    <= req_ch.mode;
      end
   end

endmodule

### rtl/afr_parser.sv
// Frame phase tracker with the result register; updates state for each byte it takes.
module afr_parser
   import afr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_take,
   afr_rsp_if.source   rsp_ch
);

   phase_type  phase_ff, phase_in, cur_phase;
   logic [7:0] wc_ff, wc_in;
   logic [7:0] pc_ff, pc_in;
   logic [8:0] pc_inc;
   logic [7:0] len_hi_ff, len_hi_in, len_lo_ff, len_lo_in;
   logic [7:0] rep_hi_ff, rep_hi_in, rep_lo_ff, rep_lo_in;
   logic       axis_ff, axis_in, place_ff, place_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result_ff, result_in;
   logic [7:0] len_hex, reply_hex, data_need, need;
   logic       counting;
   logic [7:0] b;
   logic [2:0] mode;

   assign b    = item.rx_byte;
   assign mode = item.mode;

   assign item_take = item_valid && (!rsp_valid_ff || rsp_ch.ready);

   assign len_hex   = {hex_digit(len_hi_ff), hex_digit(len_lo_ff)};
   assign reply_hex = {hex_digit(rep_hi_ff), hex_digit(rep_lo_ff)};
   assign data_need = (len_hex > cfg.length_offset) ? len_hex - cfg.length_offset : 8'd1;

   assign cur_phase = (b == CHAR_START && wc_ff == 8'd0) ? PH_HUNT : phase_ff;
   assign pc_inc    = {1'b0, pc_ff} + 9'd1;

   always_comb begin
      counting = 1'b1;
      need     = NEED_SHORT;
      if (cur_phase == PH_LEN || cur_phase == PH_CSUM) begin
         need = NEED_LONG;
      end else if (cur_phase == PH_DATA) begin
         case (mode)
            MODE_PACK, MODE_ANGLE, MODE_PLACE: need = data_need;
            MODE_RECORD:  need = cfg.record_data_count;
            MODE_VERSION: need = cfg.version_data_count;
            default:      counting = 1'b0;
         endcase
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      wc_in     = wc_ff;
      pc_in     = pc_ff;
      len_hi_in = len_hi_ff;
      len_lo_in = len_lo_ff;
      rep_hi_in = rep_hi_ff;
      rep_lo_in = rep_lo_ff;
      axis_in   = axis_ff;
      place_in  = place_ff;
      result_in = '0;
      if (item_take) begin
         if (wc_ff >= WC_LIMIT) begin
            wc_in    = 8'd0;
            phase_in = PH_HUNT;
            pc_in    = 8'd0;
            result_in.overflow_reset = 1'b1;
         end else begin
            phase_in = cur_phase;
            case (cur_phase)
               PH_HUNT: begin
                  if (b == CHAR_START) begin
                     pc_in    = 8'd0;
                     wc_in    = 8'd1;
                     phase_in = PH_ADDR;
                     result_in.stored     = 1'b1;
                     result_in.store_byte = b;
                  end
               end
               PH_EOI: begin
                  if (b == CHAR_END) begin
                     result_in.stored      = 1'b1;
                     result_in.store_index = wc_ff;
                     result_in.store_byte  = b;
                     if (mode == MODE_ANGLE) begin
                        if (reply_hex == ANGLE_0) axis_in = 1'b0;
                        if (reply_hex == ANGLE_180) axis_in = 1'b1;
                        result_in.frame_end = FEND_ANGLE;
                     end else if (mode == MODE_PLACE) begin
                        if (rep_lo_ff == CHAR_ZERO) place_in = 1'b0;
                        if (rep_lo_ff == CHAR_ONE) place_in = 1'b1;
                        result_in.frame_end = FEND_PLACE;
                     end else begin
                        result_in.frame_end = FEND_GENERAL;
                     end
                     phase_in = PH_HUNT;
                     wc_in    = 8'd0;
                  end
               end
               default: begin
                  result_in.stored      = 1'b1;
                  result_in.store_index = wc_ff;
                  result_in.store_byte  = b;
                  wc_in = wc_ff + 8'd1;
                  if (counting) begin
                     if (pc_inc >= {1'b0, need}) begin
                        pc_in    = 8'd0;
                        phase_in = next_phase(cur_phase);
                     end else begin
                        pc_in = pc_inc[7:0];
                     end
                  end
               end
            endcase
            // The length and reply characters shadow their frame positions.
            if (result_in.stored) begin
               if (result_in.store_index == IDX_LEN_HI) len_hi_in = b;
               if (result_in.store_index == IDX_LEN_LO) len_lo_in = b;
               if (result_in.store_index == IDX_REPLY_HI) rep_hi_in = b;
               if (result_in.store_index == IDX_REPLY_LO) rep_lo_in = b;
            end
         end
         result_in.angle_flag = axis_in;
         result_in.place_flag = place_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (item_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         wc_ff        <= 8'd0;
         pc_ff        <= 8'd0;
         len_hi_ff    <= 8'd0;
         len_lo_ff    <= 8'd0;
         rep_hi_ff    <= 8'd0;
         rep_lo_ff    <= 8'd0;
         axis_ff      <= 1'b0;
         place_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wc_ff        <= wc_in;
         pc_ff        <= pc_in;
         len_hi_ff    <= len_hi_in;
         len_lo_ff    <= len_lo_in;
         rep_hi_ff    <= rep_hi_in;
         rep_lo_ff    <= rep_lo_in;
         axis_ff      <= axis_in;
         place_ff     <= place_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.stored         = result_ff.stored;
   assign rsp_ch.store_index    = result_ff.store_index;
   assign rsp_ch.store_byte     = result_ff.store_byte;
   assign rsp_ch.frame_end      = result_ff.frame_end;
   assign rsp_ch.overflow_reset = result_ff.overflow_reset;
   assign rsp_ch.angle_flag     = result_ff.angle_flag;
   assign rsp_ch.place_flag     = result_ff.place_flag;

endmodule

### rtl/ascii_frame_receiver_core.sv
// A byte passes the input register and then the result register before its result is valid.
// Throughput: one byte per cycle while the result side is ready; a byte's state update finishes
// in the cycle it leaves the input register, so the next byte follows directly.
// Backpressure on the result side stalls the input register, which still takes one more byte.
// Reset (synchronous, active high) returns to the hunt phase with counts, shadow characters
// and flags at zero and the configuration registers at their defaults.
module ascii_frame_receiver_core
   import afr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   afr_req_if.sink     req_ch,
   afr_rsp_if.source   rsp_ch,
   afr_csr_if.sink     csr_ch
);

   cfg_type  cfg;
   logic     item_valid;
   item_type item;
   logic     item_take;

   afr_csr_regs u_csr_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   afr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   afr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_ch     (rsp_ch)
   );

endmodule
